>>> hw/rtl/line_break_min_badness_top_defines.svh
// Assertion macros for the line breaker checker.
// Depends on nothing; included by the checker file only.
`ifndef LINE_BREAK_MIN_BADNESS_TOP_DEFINES_SVH
`define LINE_BREAK_MIN_BADNESS_TOP_DEFINES_SVH

// Implication in the same cycle.
`define LBMB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define LBMB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lbmb_pkg.sv
// Shared types and constants of the line breaker.
// Depends on nothing; used by every module of the block.
package lbmb_pkg;

    localparam int LEN_W       = 8;
    localparam int WIDTH_W     = 7;
    localparam int HIST_DEPTH  = 64;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int WS_W        = $clog2(HIST_DEPTH + 1);
    localparam int COST_W      = 32;
    localparam int OUT_W       = 32;
    localparam int SUM_W       = 10;
    localparam int SQ_W        = 2 * WIDTH_W;
    localparam int LC_W        = SQ_W + WIDTH_W + 1;
    localparam int DIV_STEPS   = WIDTH_W;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [COST_W-1:0]  COST_MAX    = {COST_W{1'b1}};
    localparam logic [LC_W-1:0]    SINGLE_COST = LC_W'(500);
    localparam logic [7:0]         NEWLINE     = 8'd10;
    localparam logic [7:0]         CHAR_LO     = 8'd33;
    localparam logic [7:0]         CHAR_HI     = 8'd126;
    localparam logic [LEN_W-1:0]   LEN_MAX     = {LEN_W{1'b1}};
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(80);

    typedef enum logic {
        CMD_WORD,
        CMD_PARA
    } cmd_kind_t;

    // One command from the front to the back.
    typedef struct packed {
        cmd_kind_t        kind;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_READ,
        B_CHECK,
        B_DIV,
        B_SQ,
        B_MUL,
        B_ADD,
        B_WRITE,
        B_PFETCH,
        B_PEMIT
    } back_state_t;

endpackage

>>> hw/rtl/line_break_min_badness_top.sv
// Top level of the minimum-raggedness line breaker.
// Depends on lbmb_pkg, lbmb_front, lbmb_cmd_fifo and lbmb_back.
//
// Usage: text bytes enter through push/full, one beat per byte. A byte is
// taken whenever full is low; full rises only when the four-entry command
// queue is full. Results leave through empty/pop: the paragraph result is
// on min_badness, no_words and infeasible while empty is low.
// The line width register is written with cfg_we/cfg_wdata; the user must
// do so only while idle, as the block does not enforce it. Each ended
// word is scored against every earlier word that fits on its line, with
// one memory read, a restoring divider, square and multiply steps each.
// A paragraph end waits until the preceding words are done, then reads the
// last stored cost and emits the result.
// Reset clears all control state and sets the line width to 80; the
// history memories need no clearing. If the receiver does not pop, the
// next paragraph end waits in the queue and input stalls once it fills.
module line_break_min_badness_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lbmb_pkg::WIDTH_W-1:0]    cfg_wdata,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      text_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic [lbmb_pkg::OUT_W-1:0]      min_badness,
    output logic                            no_words,
    output logic                            infeasible
);

    logic [lbmb_pkg::WIDTH_W-1:0] width_reg;
    logic                         accept;
    logic                         f_valid, q_valid, q_pop;
    lbmb_pkg::cmd_t               f_cmd, q_cmd;

    assign accept = push && !full;

    // Line width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= lbmb_pkg::WIDTH_RESET;
        else if (cfg_we)
            width_reg <= cfg_wdata;
    end

    lbmb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_byte),
        .cmd_valid (f_valid),
        .cmd       (f_cmd)
    );

    lbmb_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (f_valid),
        .wr_data   (f_cmd),
        .rd_en     (q_pop),
        .rd_data   (q_cmd),
        .not_empty (q_valid),
        .is_full   (full)
    );

    lbmb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_width  (width_reg),
        .cmd_valid   (q_valid),
        .cmd         (q_cmd),
        .cmd_pop     (q_pop),
        .pop         (pop),
        .empty       (empty),
        .min_badness (min_badness),
        .no_words    (no_words),
        .infeasible  (infeasible)
    );

endmodule

>>> hw/rtl/lbmb_front.sv
// Front end: classifies text bytes and issues word and paragraph commands.
// Depends on lbmb_pkg.
module lbmb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          text_byte,
    output logic                cmd_valid,
    output lbmb_pkg::cmd_t      cmd
);

    logic                       lwn_reg, lwn_next;
    logic [lbmb_pkg::LEN_W-1:0] len_reg, len_next;
    logic                       is_nl, is_char;

    assign is_nl   = (text_byte == lbmb_pkg::NEWLINE);
    assign is_char = (text_byte >= lbmb_pkg::CHAR_LO) && (text_byte <= lbmb_pkg::CHAR_HI);

    // Word and paragraph boundary detection.
    always_comb
    begin
        lwn_next  = lwn_reg;
        len_next  = len_reg;
        cmd_valid = 1'b0;
        cmd.kind  = lbmb_pkg::CMD_WORD;
        cmd.len   = len_reg;
        if (accept)
        begin
            if (is_nl && lwn_reg)
            begin
                cmd_valid = 1'b1;
                cmd.kind  = lbmb_pkg::CMD_PARA;
                len_next  = '0;
            end
            else if (is_char)
            begin
                lwn_next = 1'b0;
                if (len_reg != lbmb_pkg::LEN_MAX)
                    len_next = len_reg + 1'b1;
            end
            else
            begin
                lwn_next = is_nl;
                if (len_reg != '0)
                begin
                    cmd_valid = 1'b1;
                    len_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lwn_reg <= 1'b1;
            len_reg <= '0;
        end
        else
        begin
            lwn_reg <= lwn_next;
            len_reg <= len_next;
        end
    end

endmodule

>>> hw/rtl/lbmb_cmd_fifo.sv
// Short command queue between the front and the back.
// Depends on lbmb_pkg.
module lbmb_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  lbmb_pkg::cmd_t wr_data,
    input  logic           rd_en,
    output lbmb_pkg::cmd_t rd_data,
    output logic           not_empty,
    output logic           is_full
);

    lbmb_pkg::cmd_t                 mem_reg [lbmb_pkg::FIFO_DEPTH];
    logic [lbmb_pkg::FIFO_AW-1:0]   wp_reg, rp_reg;
    logic [lbmb_pkg::FIFO_AW:0]     cnt_reg;

    assign not_empty = (cnt_reg != '0);
    assign is_full   = (cnt_reg == (lbmb_pkg::FIFO_AW+1)'(lbmb_pkg::FIFO_DEPTH));
    assign rd_data   = mem_reg[rp_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> hw/rtl/lbmb_back.sv
// Back end: runs the line-breaking recurrence for each word and builds results.
// Depends on lbmb_pkg.
module lbmb_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [lbmb_pkg::WIDTH_W-1:0]    line_width,
    input  logic                            cmd_valid,
    input  lbmb_pkg::cmd_t                  cmd,
    output logic                            cmd_pop,
    input  logic                            pop,
    output logic                            empty,
    output logic [lbmb_pkg::OUT_W-1:0]      min_badness,
    output logic                            no_words,
    output logic                            infeasible
);

    lbmb_pkg::back_state_t              state_reg, state_next;
    logic [lbmb_pkg::WS_W-1:0]          m_reg, m_next;
    logic [lbmb_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [lbmb_pkg::COST_W-1:0]        best_reg, best_next;
    logic [lbmb_pkg::COST_W-1:0]        prefix_reg, prefix_next;
    logic [lbmb_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [lbmb_pkg::HIST_AW-1:0]       head_reg, head_next;
    logic [lbmb_pkg::WS_W-1:0]          ws_reg, ws_next;
    logic                               over_reg, over_next;
    logic [lbmb_pkg::WIDTH_W-1:0]       rem_reg, rem_next;
    logic [lbmb_pkg::WIDTH_W-1:0]       quo_reg, quo_next;
    logic [lbmb_pkg::WIDTH_W-1:0]       dvd_reg, dvd_next;
    logic [2:0]                         cnt_reg, cnt_next;
    logic [lbmb_pkg::SQ_W-1:0]          sqa_reg, sqa_next, sqb_reg, sqb_next;
    logic [lbmb_pkg::LC_W-1:0]          lc_reg, lc_next;
    logic                               ov_reg, ov_next;
    logic [lbmb_pkg::OUT_W-1:0]         oc_reg, oc_next;
    logic                               onw_reg, onw_next, oinf_reg, oinf_next;

    logic [lbmb_pkg::LEN_W-1:0]         len_mem [lbmb_pkg::HIST_DEPTH];
    logic [lbmb_pkg::COST_W-1:0]        cost_mem [lbmb_pkg::HIST_DEPTH];
    logic [lbmb_pkg::LEN_W-1:0]         rd_len_reg;
    logic [lbmb_pkg::COST_W-1:0]        rd_cost_reg;
    logic [lbmb_pkg::HIST_AW-1:0]       len_addr, cost_addr;
    logic                               wr_en;

    logic [lbmb_pkg::SUM_W-1:0]         sum_add;
    logic [lbmb_pkg::SUM_W:0]           need;
    logic [lbmb_pkg::WIDTH_W:0]         trial;
    logic [lbmb_pkg::WIDTH_W-1:0]       qm1;
    logic [lbmb_pkg::COST_W:0]          total;
    logic [lbmb_pkg::COST_W-1:0]        total_sat;
    logic                               brk;

    assign empty       = !ov_reg;
    assign min_badness = oc_reg;
    assign no_words    = onw_reg;
    assign infeasible  = oinf_reg;

    // History addresses: entry m words back and the cost one further back.
    assign len_addr  = head_reg - m_reg[lbmb_pkg::HIST_AW-1:0];
    assign cost_addr = head_reg - m_reg[lbmb_pkg::HIST_AW-1:0] - 1'b1;

    // History memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            len_mem[head_reg]  <= len_reg;
            cost_mem[head_reg] <= best_reg;
        end
        rd_len_reg  <= len_mem[len_addr];
        rd_cost_reg <= cost_mem[cost_addr];
    end

    // Datapath helpers for the current step.
    assign sum_add = sum_reg + ((m_reg != '0) ? lbmb_pkg::SUM_W'(rd_len_reg) : '0);
    assign need    = (lbmb_pkg::SUM_W+1)'(sum_add) + (lbmb_pkg::SUM_W+1)'(m_reg);
    assign brk     = (need > (lbmb_pkg::SUM_W+1)'(line_width))
                     || ((m_reg == ws_reg)
                         && (ws_reg == lbmb_pkg::WS_W'(lbmb_pkg::HIST_DEPTH)));
    assign trial   = {rem_reg, dvd_reg[lbmb_pkg::WIDTH_W-1]};
    assign qm1     = quo_reg - 1'b1;
    assign total   = (lbmb_pkg::COST_W+1)'(prefix_reg) + (lbmb_pkg::COST_W+1)'(lc_reg);
    assign total_sat = total[lbmb_pkg::COST_W] ? lbmb_pkg::COST_MAX
                                               : total[lbmb_pkg::COST_W-1:0];

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next  = state_reg;
        m_next      = m_reg;
        sum_next    = sum_reg;
        best_next   = best_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        head_next   = head_reg;
        ws_next     = ws_reg;
        over_next   = over_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvd_next    = dvd_reg;
        cnt_next    = cnt_reg;
        sqa_next    = sqa_reg;
        sqb_next    = sqb_reg;
        lc_next     = lc_reg;
        ov_next     = ov_reg;
        oc_next     = oc_reg;
        onw_next    = onw_reg;
        oinf_next   = oinf_reg;
        cmd_pop     = 1'b0;
        wr_en       = 1'b0;
        if (pop && ov_reg)
            ov_next = 1'b0;
        unique case (state_reg)
            lbmb_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == lbmb_pkg::CMD_WORD)
                    begin
                        cmd_pop    = 1'b1;
                        len_next   = cmd.len;
                        sum_next   = lbmb_pkg::SUM_W'(cmd.len);
                        m_next     = '0;
                        best_next  = lbmb_pkg::COST_MAX;
                        if (cmd.len > lbmb_pkg::LEN_W'(line_width))
                            over_next = 1'b1;
                        state_next = lbmb_pkg::B_READ;
                    end
                    else if (!ov_reg)
                    begin
                        cmd_pop    = 1'b1;
                        m_next     = '0;
                        state_next = lbmb_pkg::B_PFETCH;
                    end
                end
            end
            lbmb_pkg::B_READ:
            begin
                state_next = lbmb_pkg::B_CHECK;
            end
            lbmb_pkg::B_CHECK:
            begin
                sum_next    = sum_add;
                prefix_next = (m_reg < ws_reg) ? rd_cost_reg : '0;
                if (brk)
                    state_next = lbmb_pkg::B_WRITE;
                else if (m_reg == '0)
                begin
                    lc_next    = (sum_reg == lbmb_pkg::SUM_W'(line_width))
                                 ? '0 : lbmb_pkg::SINGLE_COST;
                    state_next = lbmb_pkg::B_ADD;
                end
                else
                begin
                    dvd_next   = line_width - lbmb_pkg::WIDTH_W'(sum_add);
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = lbmb_pkg::B_DIV;
                end
            end
            lbmb_pkg::B_DIV:
            begin
                // One quotient bit per cycle, restoring form.
                if (trial >= (lbmb_pkg::WIDTH_W+1)'(m_reg))
                begin
                    rem_next = lbmb_pkg::WIDTH_W'(trial - (lbmb_pkg::WIDTH_W+1)'(m_reg));
                    quo_next = {quo_reg[lbmb_pkg::WIDTH_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[lbmb_pkg::WIDTH_W-1:0];
                    quo_next = {quo_reg[lbmb_pkg::WIDTH_W-2:0], 1'b0};
                end
                dvd_next = {dvd_reg[lbmb_pkg::WIDTH_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'(lbmb_pkg::DIV_STEPS - 1))
                    state_next = lbmb_pkg::B_SQ;
            end
            lbmb_pkg::B_SQ:
            begin
                sqa_next   = qm1 * qm1;
                sqb_next   = quo_reg * quo_reg;
                state_next = lbmb_pkg::B_MUL;
            end
            lbmb_pkg::B_MUL:
            begin
                lc_next = lbmb_pkg::LC_W'(sqa_reg * (m_reg - lbmb_pkg::WS_W'(rem_reg)))
                        + lbmb_pkg::LC_W'(sqb_reg * rem_reg);
                state_next = lbmb_pkg::B_ADD;
            end
            lbmb_pkg::B_ADD:
            begin
                if (total_sat < best_reg)
                    best_next = total_sat;
                if (m_reg == ws_reg)
                    state_next = lbmb_pkg::B_WRITE;
                else
                begin
                    m_next     = m_reg + 1'b1;
                    state_next = lbmb_pkg::B_READ;
                end
            end
            lbmb_pkg::B_WRITE:
            begin
                wr_en     = 1'b1;
                head_next = head_reg + 1'b1;
                if (ws_reg != lbmb_pkg::WS_W'(lbmb_pkg::HIST_DEPTH))
                    ws_next = ws_reg + 1'b1;
                state_next = lbmb_pkg::B_IDLE;
            end
            lbmb_pkg::B_PFETCH:
            begin
                state_next = lbmb_pkg::B_PEMIT;
            end
            lbmb_pkg::B_PEMIT:
            begin
                ov_next    = 1'b1;
                onw_next   = (ws_reg == '0);
                oinf_next  = over_reg;
                oc_next    = ((ws_reg != '0) && !over_reg) ? rd_cost_reg : '0;
                head_next  = '0;
                ws_next    = '0;
                over_next  = 1'b0;
                state_next = lbmb_pkg::B_IDLE;
            end
            default:
            begin
                state_next = lbmb_pkg::B_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lbmb_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            ws_reg   <= '0;
            over_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            ws_reg   <= ws_next;
            over_reg <= over_next;
            ov_reg   <= ov_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        sum_reg    <= sum_next;
        best_reg   <= best_next;
        prefix_reg <= prefix_next;
        len_reg    <= len_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvd_reg    <= dvd_next;
        cnt_reg    <= cnt_next;
        sqa_reg    <= sqa_next;
        sqb_reg    <= sqb_next;
        lc_reg     <= lc_next;
        oc_reg     <= oc_next;
        onw_reg    <= onw_next;
        oinf_reg   <= oinf_next;
    end

endmodule

>>> hw/rtl/lbmb_checker.sv
// Port-level checker for the line breaker, bound to the top level.
// Depends on line_break_min_badness_top_defines.svh and lbmb_pkg.
`include "line_break_min_badness_top_defines.svh"

module lbmb_assertions (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         empty,
    input  logic                         pop,
    input  logic [lbmb_pkg::OUT_W-1:0]   min_badness,
    input  logic                         no_words,
    input  logic                         infeasible
);

    // A waiting result holds until it is taken.
    `LBMB_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(min_badness), "result moved")

    // An empty paragraph cannot hold an overlong word.
    `LBMB_ASSERT_NOW(a_flags, !empty, !(no_words && infeasible), "both flags set")

    // Flagged results carry zero badness.
    `LBMB_ASSERT_NOW(a_nw_zero, !empty && no_words, min_badness == '0, "empty para cost")

    `LBMB_ASSERT_NOW(a_inf_zero, !empty && infeasible, min_badness == '0, "overlong cost")

endmodule

bind line_break_min_badness_top lbmb_assertions u_lbmb_assertions (.*);
